@@ design/kmms_pkg.sv @@
// ----------------------------------------------------------------------------
// kmms_pkg: shared types and constants for the k-way merge selector
// Lane count, field widths and the sequencer state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package kmms_pkg;

  // number of head registers (runs)
  localparam int unsigned MAX_LANES = 16;
  // lane index width, fixed by the item format
  localparam int unsigned LANE_W    = 4;
  // lane count width, holds 0..MAX_LANES and beyond
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned KEY_W     = 64;
  localparam int unsigned PAY_W     = 64;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_EMIT
  } seq_state_e;

  // control from the sequencer to the compare unit, aligned with read data
  typedef struct packed {
    logic              clear;
    logic              cmp_en;
    logic              lane_valid;
    logic [LANE_W-1:0] lane;
  } cmp_ctl_t;

endpackage : kmms_pkg

`default_nettype wire

@@ design/kway_merge_min_select_unit.sv @@
// ----------------------------------------------------------------------------
// kway_merge_min_select_unit: k-way merge by linear minimum selection
// Holds one head per run, emits the smallest key and the lane to refill.
// ----------------------------------------------------------------------------
//  channel   | handshake                 | payload
//  ----------+---------------------------+------------------------------------
//  item in   | start, busy               | lane_i, has_item_i, key_i, payload_i
//  result    | out_valid_o (1 cycle)     | out_key_o, out_payload_o,
//            |                           | refill_lane_o, merge_done_o
//  config    | cfg_valid_i, cfg_ready_o  | cfg_data_i (lanes in use)
//
//  A load item that does not finish the load phase leaves the unit idle.
//  Any other item runs a scan of the n lanes in use, then a wait state and
//  an emit state: one shared comparator walks the heads one per cycle
//  through the registered read port of the head memory. The result strobe
//  shows in the cycle busy drops. Reset clears valid bits, load count and
//  phase; lanes in use resets to 16. The receiver cannot stall results.
// ----------------------------------------------------------------------------
`default_nettype none

module kway_merge_min_select_unit (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [kmms_pkg::LANE_W-1:0]          lane_i,
  input  wire logic                                 has_item_i,
  input  wire logic signed [kmms_pkg::KEY_W-1:0]    key_i,
  input  wire logic [kmms_pkg::PAY_W-1:0]           payload_i,
  output logic                                      out_valid_o,
  output logic signed [kmms_pkg::KEY_W-1:0]         out_key_o,
  output logic [kmms_pkg::PAY_W-1:0]                out_payload_o,
  output logic [kmms_pkg::LANE_W-1:0]               refill_lane_o,
  output logic                                      merge_done_o,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [kmms_pkg::CNT_W-1:0]           cfg_data_i
);
  import kmms_pkg::*;

  logic                    wr_en;
  logic                    rd_en;
  logic [LANE_W-1:0]       rd_lane;
  logic signed [KEY_W-1:0] rd_key;
  logic [PAY_W-1:0]        rd_pay;
  cmp_ctl_t                cmp_ctl;
  logic                    emit;
  logic                    found;
  logic signed [KEY_W-1:0] best_key;
  logic [PAY_W-1:0]        best_pay;
  logic [LANE_W-1:0]       best_lane;

  logic                    out_valid_q;
  logic signed [KEY_W-1:0] out_key_q;
  logic [PAY_W-1:0]        out_pay_q;
  logic [LANE_W-1:0]       out_lane_q;
  logic                    out_done_q;

  kmms_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .lane_i      (lane_i),
    .has_item_i  (has_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .found_i     (found),
    .busy_o      (busy),
    .cfg_ready_o (cfg_ready_o),
    .wr_en_o     (wr_en),
    .rd_en_o     (rd_en),
    .rd_lane_o   (rd_lane),
    .cmp_o       (cmp_ctl),
    .emit_o      (emit)
  );

  kmms_head_mem u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_lane_i (lane_i),
    .wr_key_i  (key_i),
    .wr_pay_i  (payload_i),
    .rd_en_i   (rd_en),
    .rd_lane_i (rd_lane),
    .rd_key_o  (rd_key),
    .rd_pay_o  (rd_pay)
  );

  kmms_min_cmp u_cmp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (cmp_ctl),
    .rd_key_i    (rd_key),
    .rd_pay_i    (rd_pay),
    .found_o     (found),
    .best_key_o  (best_key),
    .best_pay_o  (best_pay),
    .best_lane_o (best_lane)
  );

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= emit;
    end
  end

  // result fields; done result carries zeros
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_key_q  <= found ? best_key  : '0;
      out_pay_q  <= found ? best_pay  : '0;
      out_lane_q <= found ? best_lane : '0;
      out_done_q <= !found;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_key_o     = out_key_q;
  assign out_payload_o = out_pay_q;
  assign refill_lane_o = out_lane_q;
  assign merge_done_o  = out_done_q;

endmodule : kway_merge_min_select_unit

`default_nettype wire

@@ design/kmms_head_mem.sv @@
// ----------------------------------------------------------------------------
// kmms_head_mem: head key and payload storage
// One write port (load/refill) and one registered read port (scan).
// ----------------------------------------------------------------------------
`default_nettype none

module kmms_head_mem (
  input  wire logic                                 clk_i,
  input  wire logic                                 wr_en_i,
  input  wire logic [kmms_pkg::LANE_W-1:0]          wr_lane_i,
  input  wire logic signed [kmms_pkg::KEY_W-1:0]    wr_key_i,
  input  wire logic [kmms_pkg::PAY_W-1:0]           wr_pay_i,
  input  wire logic                                 rd_en_i,
  input  wire logic [kmms_pkg::LANE_W-1:0]          rd_lane_i,
  output logic signed [kmms_pkg::KEY_W-1:0]         rd_key_o,
  output logic [kmms_pkg::PAY_W-1:0]                rd_pay_o
);
  import kmms_pkg::*;

  logic signed [KEY_W-1:0] key_mem [MAX_LANES];
  logic [PAY_W-1:0]        pay_mem [MAX_LANES];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      key_mem[wr_lane_i] <= wr_key_i;
      pay_mem[wr_lane_i] <= wr_pay_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_key_o <= key_mem[rd_lane_i];
      rd_pay_o <= pay_mem[rd_lane_i];
    end
  end

endmodule : kmms_head_mem

`default_nettype wire

@@ design/kmms_min_cmp.sv @@
// ----------------------------------------------------------------------------
// kmms_min_cmp: shared signed comparator and running minimum
// Takes one head per cycle; strict less-than keeps the lowest lane on ties.
// ----------------------------------------------------------------------------
`default_nettype none

module kmms_min_cmp (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire kmms_pkg::cmp_ctl_t                   ctl_i,
  input  wire logic signed [kmms_pkg::KEY_W-1:0]    rd_key_i,
  input  wire logic [kmms_pkg::PAY_W-1:0]           rd_pay_i,
  output logic                                      found_o,
  output logic signed [kmms_pkg::KEY_W-1:0]         best_key_o,
  output logic [kmms_pkg::PAY_W-1:0]                best_pay_o,
  output logic [kmms_pkg::LANE_W-1:0]               best_lane_o
);
  import kmms_pkg::*;

  logic                    found_q;
  logic signed [KEY_W-1:0] best_key_q;
  logic [PAY_W-1:0]        best_pay_q;
  logic [LANE_W-1:0]       best_lane_q;
  logic                    take;

  // new minimum: valid head and first seen or strictly smaller
  assign take = ctl_i.cmp_en && ctl_i.lane_valid && (!found_q || (rd_key_i < best_key_q));

  // found flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctl_i.clear) begin
      found_q <= 1'b0;
    end else if (take) begin
      found_q <= 1'b1;
    end
  end

  // best head
  always_ff @(posedge clk_i) begin
    if (take) begin
      best_key_q  <= rd_key_i;
      best_pay_q  <= rd_pay_i;
      best_lane_q <= ctl_i.lane;
    end
  end

  assign found_o     = found_q;
  assign best_key_o  = best_key_q;
  assign best_pay_o  = best_pay_q;
  assign best_lane_o = best_lane_q;

endmodule : kmms_min_cmp

`default_nettype wire

@@ design/kmms_seq.sv @@
// ----------------------------------------------------------------------------
// kmms_seq: load/merge sequencer
// Tracks valid bits, load count and phase, and walks the lanes for the scan.
// ----------------------------------------------------------------------------
`default_nettype none

module kmms_seq (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [kmms_pkg::LANE_W-1:0]    lane_i,
  input  wire logic                           has_item_i,
  input  wire logic                           cfg_valid_i,
  input  wire logic [kmms_pkg::CNT_W-1:0]     cfg_data_i,
  input  wire logic                           found_i,
  output logic                                busy_o,
  output logic                                cfg_ready_o,
  output logic                                wr_en_o,
  output logic                                rd_en_o,
  output logic [kmms_pkg::LANE_W-1:0]         rd_lane_o,
  output kmms_pkg::cmp_ctl_t                  cmp_o,
  output logic                                emit_o
);
  import kmms_pkg::*;

  seq_state_e            state_q, state_d;
  logic [LANE_W-1:0]     idx_q, idx_d;
  cmp_ctl_t              cmp_q, cmp_d;
  logic [MAX_LANES-1:0]  valid_q;
  logic [CNT_W-1:0]      loaded_q;
  logic                  merging_q;
  logic [CNT_W-1:0]      lanes_q;

  logic [CNT_W-1:0]      active;
  logic [CNT_W-1:0]      loaded_inc;
  logic                  accept;
  logic                  lane_ok;
  logic                  load_done;
  logic                  go_scan;
  logic                  last_idx;
  logic                  clear_all;

  // lanes in use, clamped to 1..MAX_LANES
  always_comb begin
    if (lanes_q == '0) begin
      active = CNT_W'(1);
    end else if (lanes_q > CNT_W'(MAX_LANES)) begin
      active = CNT_W'(MAX_LANES);
    end else begin
      active = lanes_q;
    end
  end

  assign accept     = start_i && (state_q == ST_IDLE);
  assign lane_ok    = ({1'b0, lane_i} < active);
  assign loaded_inc = loaded_q + CNT_W'(1);
  assign load_done  = (loaded_inc >= active);
  assign go_scan    = accept && (merging_q || load_done);
  assign last_idx   = ({1'b0, idx_q} == (active - CNT_W'(1)));
  assign clear_all  = (state_q == ST_EMIT) && !found_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (go_scan) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (last_idx) state_d = ST_WAIT;
      end
      ST_WAIT: state_d = ST_EMIT;
      ST_EMIT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and scan control
  always_comb begin
    busy_o           = (state_q != ST_IDLE);
    cfg_ready_o      = (state_q == ST_IDLE);
    wr_en_o          = accept && lane_ok && has_item_i;
    rd_en_o          = (state_q == ST_SCAN);
    rd_lane_o        = idx_q;
    emit_o           = (state_q == ST_EMIT);
    idx_d            = idx_q;
    cmp_d.clear      = go_scan;
    cmp_d.cmp_en     = (state_q == ST_SCAN);
    cmp_d.lane_valid = valid_q[idx_q];
    cmp_d.lane       = idx_q;
    if (go_scan) begin
      idx_d = '0;
    end else if (state_q == ST_SCAN) begin
      idx_d = idx_q + LANE_W'(1);
    end
  end

  assign cmp_o = cmp_q;

  // sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      cmp_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cmp_q   <= cmp_d;
    end
  end

  // head valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clear_all) begin
      valid_q <= '0;
    end else if (accept && lane_ok) begin
      valid_q[lane_i] <= has_item_i;
    end
  end

  // load count and phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q  <= '0;
      merging_q <= 1'b0;
    end else if (clear_all) begin
      loaded_q  <= '0;
      merging_q <= 1'b0;
    end else if (accept && !merging_q) begin
      loaded_q <= loaded_inc;
      if (load_done) merging_q <= 1'b1;
    end
  end

  // lanes in use register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lanes_q <= CNT_W'(MAX_LANES);
    end else if (cfg_valid_i && cfg_ready_o) begin
      lanes_q <= cfg_data_i;
    end
  end

endmodule : kmms_seq

`default_nettype wire

@@ design/kmms_checker.sv @@
// ----------------------------------------------------------------------------
// kmms_checker: port-level checks for the k-way merge selector
// Watches the top-level ports only; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module kmms_checker (
  input wire logic                                 clk_i,
  input wire logic                                 rst_ni,
  input wire logic                                 start,
  input wire logic                                 busy,
  input wire logic                                 out_valid_o,
  input wire logic signed [kmms_pkg::KEY_W-1:0]    out_key_o,
  input wire logic [kmms_pkg::PAY_W-1:0]           out_payload_o,
  input wire logic [kmms_pkg::LANE_W-1:0]          refill_lane_o,
  input wire logic                                 merge_done_o
);
  import kmms_pkg::*;

  // result shows as the unit goes idle
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !busy)
    else $error("result strobe while busy");

  // never two result strobes in a row
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |=> !out_valid_o)
    else $error("result strobe held longer than one cycle");

  // done result carries zero fields
  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && merge_done_o) |->
      (out_key_o == '0) && (out_payload_o == '0) && (refill_lane_o == '0))
    else $error("done result with nonzero fields");

  // busy only rises after start was high
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a start");

endmodule : kmms_checker

bind kway_merge_min_select_unit kmms_checker u_kmms_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .out_valid_o   (out_valid_o),
  .out_key_o     (out_key_o),
  .out_payload_o (out_payload_o),
  .refill_lane_o (refill_lane_o),
  .merge_done_o  (merge_done_o)
);

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the k-way merge minimum selector
// Feeds sorted runs through load and merge phases, follows the block's
// refill requests, mixes in stray and broken items and lane count changes,
// and checks every result strobe against a cycle-free model of the heads.
// ----------------------------------------------------------------------------

module tb;
  import kmms_pkg::*;

  // run control
  localparam int RANDOM_ITEMS   = 900;
  localparam int WATCHDOG_LIMIT = 2000;
  // longer than the slowest item at full lane count
  localparam int SETTLE_CYCLES  = MAX_LANES + 8;
  localparam int REPORT_CAP     = 100;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [PAY_W-1:0]        pay_t;
  typedef logic [LANE_W-1:0]       lane_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  localparam key_t KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam key_t KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

  // one emitted head, or the end-of-merge marker
  typedef struct packed {
    key_t  key;
    pay_t  pay;
    lane_t lane;
    logic  done;
  } merge_out_t;

  // --------------------------------------------------------------------------
  // Head model and expected-result store
  // --------------------------------------------------------------------------
  class merge_checker;
    cnt_t       lanes_cfg;
    key_t       head_key [MAX_LANES];
    pay_t       head_pay [MAX_LANES];
    bit         head_vld [MAX_LANES];
    cnt_t       loaded;
    bit         merging;
    lane_t      last_refill;
    merge_out_t pending_out [$];
    int         fail_count;

    function new();
      lanes_cfg   = cnt_t'(MAX_LANES);
      loaded      = '0;
      merging     = 1'b0;
      last_refill = '0;
      fail_count  = 0;
      foreach (head_vld[i]) head_vld[i] = 1'b0;
    endfunction

    // effective lane count: 0 acts as 1, large values clamp
    function int active_lanes();
      int n;
      n = int'(lanes_cfg);
      if (n == 0) n = 1;
      if (n > MAX_LANES) n = MAX_LANES;
      return n;
    endfunction

    function void set_lanes(cnt_t v);
      lanes_cfg = v;
    endfunction

    // update heads for one accepted item, queue the selection it causes
    function void take_item(lane_t ln, logic has, key_t k, pay_t p);
      merge_out_t r;
      int         best;
      bit         found;
      if (int'(ln) < active_lanes()) begin
        if (has) begin
          head_key[ln] = k;
          head_pay[ln] = p;
          head_vld[ln] = 1'b1;
        end else begin
          head_vld[ln] = 1'b0;
        end
      end
      if (!merging) begin
        loaded = loaded + 1'b1;
        if (int'(loaded) < active_lanes()) return;
        merging = 1'b1;
      end
      // smallest signed key, lowest lane on ties
      found = 1'b0;
      best  = 0;
      for (int i = 0; i < active_lanes(); i++) begin
        if (head_vld[i] && (!found || head_key[i] < head_key[best])) begin
          best  = i;
          found = 1'b1;
        end
      end
      r = '0;
      if (found) begin
        r.key  = head_key[best];
        r.pay  = head_pay[best];
        r.lane = lane_t'(best);
      end else begin
        r.done = 1'b1;
        foreach (head_vld[i]) head_vld[i] = 1'b0;
        loaded  = '0;
        merging = 1'b0;
      end
      last_refill = r.lane;
      pending_out.push_back(r);
    endfunction

    task report(string msg);
      fail_count++;
      if (fail_count <= REPORT_CAP) $display("%0t ns: %s", $time, msg);
    endtask

    task check_result(key_t k, pay_t p, lane_t ln, logic done);
      merge_out_t w;
      if (pending_out.size() == 0) begin
        report($sformatf("result with none expected: key=%h lane=%0d done=%b",
                         k, ln, done));
        return;
      end
      w = pending_out.pop_front();
      if (k !== w.key)
        report($sformatf("out_key: got %h want %h", k, w.key));
      if (p !== w.pay)
        report($sformatf("out_payload: got %h want %h", p, w.pay));
      if (ln !== w.lane)
        report($sformatf("refill_lane: got %0d want %0d", ln, w.lane));
      if (done !== w.done)
        report($sformatf("merge_done: got %b want %b", done, w.done));
    endtask

    task check_drained();
      if (pending_out.size() != 0)
        report($sformatf("%0d expected results never arrived", pending_out.size()));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, DUT
  // --------------------------------------------------------------------------
  logic  clk_i = 1'b0;
  logic  rst_ni;
  logic  start;
  logic  busy;
  lane_t lane_i;
  logic  has_item_i;
  key_t  key_i;
  pay_t  payload_i;
  logic  out_valid_o;
  key_t  out_key_o;
  pay_t  out_payload_o;
  lane_t refill_lane_o;
  logic  merge_done_o;
  logic  cfg_valid_i;
  logic  cfg_ready_o;
  cnt_t  cfg_data_i;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  kway_merge_min_select_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .lane_i        (lane_i),
    .has_item_i    (has_item_i),
    .key_i         (key_i),
    .payload_i     (payload_i),
    .out_valid_o   (out_valid_o),
    .out_key_o     (out_key_o),
    .out_payload_o (out_payload_o),
    .refill_lane_o (refill_lane_o),
    .merge_done_o  (merge_done_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Monitor: handshakes, checking, watchdog
  // --------------------------------------------------------------------------
  merge_checker merge_chk;
  int items_accepted = 0;
  int cfg_writes     = 0;
  int outstanding    = 0;
  int quiet_cycles   = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o)
        merge_chk.check_result(out_key_o, out_payload_o, refill_lane_o, merge_done_o);
      if (start && !busy) begin
        merge_chk.take_item(lane_i, has_item_i, key_i, payload_i);
        items_accepted++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        merge_chk.set_lanes(cfg_data_i);
        cfg_writes++;
      end
      outstanding = merge_chk.pending_out.size();
      if (out_valid_o || (start && !busy) || (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", quiet_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  bit   idling_on;
  key_t run_key [MAX_LANES][$];
  pay_t run_pay [MAX_LANES][$];

  function automatic key_t rand_key();
    case ($urandom_range(0, 9))
      0:       return KEY_MIN;
      1:       return KEY_MAX;
      2, 3:    return key_t'(int'($urandom_range(0, 8)) - 4); // ties likely
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic pay_t rand_pay();
    return {$urandom, $urandom};
  endfunction

  // random sender gap, only when idling is enabled
  task automatic sender_gap();
    int len;
    if (idling_on && $urandom_range(0, 5) == 0) begin
      len = $urandom_range(1, 14);
      start <= 1'b0;
      repeat (len) @(posedge clk_i);
    end
  endtask

  // present one item and return in the step it is accepted
  task automatic send_item(lane_t ln, logic has, key_t k, pay_t p);
    int target;
    sender_gap();
    target = items_accepted + 1;
    start      <= 1'b1;
    lane_i     <= ln;
    has_item_i <= has;
    key_i      <= k;
    payload_i  <= p;
    wait (items_accepted == target);
  endtask

  // hold the sender until every pending result has come out
  task automatic hold_for_results();
    if (outstanding != 0) begin
      start <= 1'b0;
      wait (outstanding == 0);
    end
  endtask

  // drain and let the datapath go quiet before touching the register
  task automatic settle();
    start <= 1'b0;
    wait (outstanding == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_lanes(cnt_t v);
    int target;
    settle();
    target = cfg_writes + 1;
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    wait (cfg_writes == target);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic cnt_t pick_lanes();
    case ($urandom_range(0, 9))
      0:       return cnt_t'(0);
      1:       return cnt_t'(MAX_LANES);
      2:       return cnt_t'($urandom_range(MAX_LANES + 1, 31));
      3:       return cnt_t'(31);
      default: return cnt_t'($urandom_range(1, 6));
    endcase
  endfunction

  // sorted runs for the lanes in use, short ones at high lane counts
  task automatic build_runs(int n, int max_len);
    key_t ks [$];
    int   len;
    for (int l = 0; l < MAX_LANES; l++) begin
      run_key[l].delete();
      run_pay[l].delete();
    end
    for (int l = 0; l < n; l++) begin
      len = $urandom_range(0, max_len);
      ks.delete();
      repeat (len) ks.push_back(rand_key());
      ks.sort();
      foreach (ks[i]) begin
        run_key[l].push_back(ks[i]);
        run_pay[l].push_back(rand_pay());
      end
    end
  endtask

  // next element of a run, or the exhausted marker with junk fields
  task automatic feed_lane(lane_t ln);
    if (run_key[ln].size() > 0)
      send_item(ln, 1'b1, run_key[ln].pop_front(), run_pay[ln].pop_front());
    else
      send_item(ln, 1'b0, rand_key(), rand_pay());
  endtask

  task automatic send_stray();
    send_item(lane_t'($urandom_range(0, MAX_LANES - 1)), 1'($urandom_range(0, 1)),
              rand_key(), rand_pay());
  endtask

  // one item per lane in use, in order or shuffled
  task automatic load_phase(bit noisy);
    int order [$];
    int n, j, tmp;
    n = merge_chk.active_lanes();
    for (int i = 0; i < n; i++) order.push_back(i);
    if ($urandom_range(0, 1) == 1) begin
      for (int i = n - 1; i > 0; i--) begin
        j        = $urandom_range(0, i);
        tmp      = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
    end
    foreach (order[i]) begin
      if (noisy && $urandom_range(0, 19) == 0) send_stray();
      else feed_lane(lane_t'(order[i]));
    end
  endtask

  // follow refill requests until the done result
  task automatic merge_phase(bit noisy, bit may_lower);
    int steps;
    steps = 0;
    while (merge_chk.merging) begin
      // lane count lowered mid-merge, upper heads drop out of the selection
      if (may_lower && steps == 3 && merge_chk.active_lanes() > 1)
        write_lanes(cnt_t'($urandom_range(1, merge_chk.active_lanes() - 1)));
      if (noisy && $urandom_range(0, 19) == 0) begin
        send_stray();
      end else begin
        if ($urandom_range(0, 29) == 0) hold_for_results();
        feed_lane(merge_chk.last_refill);
      end
      steps++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int item_goal;
    bit noisy;
    int n;
    merge_chk   = new();
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    lane_i      <= '0;
    has_item_i  <= 1'b0;
    key_i       <= '0;
    payload_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    idling_on   = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // two lanes: extreme keys, tie to lowest lane, refill of the wrong lane,
    // refill beyond the lanes in use, then exhaustion
    write_lanes(cnt_t'(2));
    send_item(4'd0, 1'b1, KEY_MIN, '1);
    send_item(4'd1, 1'b1, KEY_MAX, '0);
    send_item(4'd0, 1'b1, KEY_MAX, pay_t'(5));
    send_item(4'd1, 1'b0, '0, '1);
    send_item(4'd15, 1'b1, key_t'(-1), '1);
    send_item(4'd0, 1'b0, KEY_MAX, '0);

    // zero lanes act as one; out-of-range load still completes the load
    write_lanes(cnt_t'(0));
    send_item(4'd3, 1'b1, '0, '1);
    send_item(4'd0, 1'b0, KEY_MIN, '0);

    // three lanes: sign ordering of negative, zero and positive keys
    write_lanes(cnt_t'(3));
    send_item(4'd2, 1'b1, key_t'(0), pay_t'(2));
    send_item(4'd1, 1'b1, key_t'(-1), pay_t'(1));
    send_item(4'd0, 1'b1, key_t'(1), '1);
    send_item(4'd1, 1'b0, '0, '0);
    send_item(4'd2, 1'b0, '0, '0);
    send_item(4'd0, 1'b0, '0, '0);

    // random merges; the tail runs without gaps
    item_goal = items_accepted + RANDOM_ITEMS;
    while (items_accepted < item_goal) begin
      idling_on = (items_accepted < item_goal - RANDOM_ITEMS / 6) &&
                  ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) == 0) write_lanes(pick_lanes());
      n = merge_chk.active_lanes();
      build_runs(n, (n > 8) ? 2 : 4);
      noisy = ($urandom_range(0, 3) == 0);
      load_phase(noisy);
      merge_phase(noisy, $urandom_range(0, 7) == 0);
    end

    // drain and finish
    start <= 1'b0;
    wait (outstanding == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    merge_chk.check_drained();
    if (merge_chk.fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
